>>> hw/rtl/qrs_pkg.sv
// ============================================================================
// Quadratic root solver package
// Shared widths, case codes and pipeline word types of the quadratic root
// solver and its square root and divider pipelines.
// ============================================================================
package qrs_pkg;

    localparam int COEF_WIDTH  = 16;
    localparam int ROOT_FRAC   = 16;
    localparam int TOL_WIDTH   = 8;
    localparam int DISC_WIDTH  = 40;
    localparam int OUT_WIDTH   = 32;

    localparam int SQRT_SHIFT  = (31 - COEF_WIDTH < 0) ? 0 :
                                 ((31 - COEF_WIDTH > ROOT_FRAC) ? ROOT_FRAC : 31 - COEF_WIDTH);
    localparam int POST_SHIFT  = ROOT_FRAC - SQRT_SHIFT;

    localparam int PROD_WIDTH  = 2 * COEF_WIDTH;
    localparam int D_WIDTH     = 2 * COEF_WIDTH + 2;
    localparam int RAD_WIDTH   = D_WIDTH + 2 * SQRT_SHIFT;
    localparam int ROOT_WIDTH  = RAD_WIDTH / 2;
    localparam int SREM_WIDTH  = ROOT_WIDTH + 2;
    localparam int N_WIDTH     = ROOT_WIDTH + 2;
    localparam int DEN_WIDTH   = COEF_WIDTH + 1;
    localparam int NUM_A       = COEF_WIDTH + ROOT_FRAC;
    localparam int NUM_B       = N_WIDTH + POST_SHIFT;
    localparam int NUM_WIDTH   = ((NUM_A > NUM_B) ? NUM_A : NUM_B) + 1;
    localparam int QUO_WIDTH   = NUM_WIDTH;

    typedef enum logic [2:0] {
        CASE_INF    = 3'd0,
        CASE_NONE   = 3'd1,
        CASE_LINEAR = 3'd2,
        CASE_TWO    = 3'd3,
        CASE_DOUBLE = 3'd4,
        CASE_CPLX   = 3'd5
    } case_t;

    typedef struct packed {
        case_t                         code;
        logic signed [DISC_WIDTH-1:0]  disc;
        logic [NUM_WIDTH-1:0]          num1;
        logic [DEN_WIDTH-1:0]          den1;
        logic                          neg1;
        logic signed [COEF_WIDTH-1:0]  b;
        logic                          a_neg;
        logic [DEN_WIDTH-1:0]          den;
    } sq_meta_t;

    typedef struct packed {
        case_t                         code;
        logic signed [DISC_WIDTH-1:0]  disc;
        logic                          neg1;
        logic                          neg2;
    } div_meta_t;

endpackage

>>> hw/rtl/qrs_sqrt.sv
// ============================================================================
// Pipelined integer square root
// Floor square root of the radicand, one result bit per register stage, with
// the item's word carried alongside.
// ============================================================================
module qrs_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [qrs_pkg::RAD_WIDTH-1:0]   in_rad,
    input  qrs_pkg::sq_meta_t               in_meta,
    output logic                            out_valid,
    output logic [qrs_pkg::ROOT_WIDTH-1:0]  out_root,
    output qrs_pkg::sq_meta_t               out_meta
);
    import qrs_pkg::*;

    logic                   valid_reg  [ROOT_WIDTH];
    logic                   valid_next [ROOT_WIDTH];
    logic [RAD_WIDTH-1:0]   rad_reg    [ROOT_WIDTH];
    logic [RAD_WIDTH-1:0]   rad_next   [ROOT_WIDTH];
    logic [SREM_WIDTH-1:0]  rem_reg    [ROOT_WIDTH];
    logic [SREM_WIDTH-1:0]  rem_next   [ROOT_WIDTH];
    logic [ROOT_WIDTH-1:0]  root_reg   [ROOT_WIDTH];
    logic [ROOT_WIDTH-1:0]  root_next  [ROOT_WIDTH];
    sq_meta_t               meta_reg   [ROOT_WIDTH];
    sq_meta_t               meta_next  [ROOT_WIDTH];

    always_comb
    begin
        logic [RAD_WIDTH-1:0]  rad_src;
        logic [SREM_WIDTH-1:0] rem_src;
        logic [ROOT_WIDTH-1:0] root_src;
        logic [SREM_WIDTH-1:0] rem_sh;
        logic [SREM_WIDTH-1:0] trial;
        logic                  ge;
        for (int k = 0; k < ROOT_WIDTH; k++)
        begin
            if (k == 0)
            begin
                rad_src       = in_rad;
                rem_src       = '0;
                root_src      = '0;
                valid_next[k] = in_valid;
                meta_next[k]  = in_meta;
            end
            else
            begin
                rad_src       = rad_reg[k-1];
                rem_src       = rem_reg[k-1];
                root_src      = root_reg[k-1];
                valid_next[k] = valid_reg[k-1];
                meta_next[k]  = meta_reg[k-1];
            end
            rem_sh       = {rem_src[SREM_WIDTH-3:0], rad_src[RAD_WIDTH-1 -: 2]};
            trial        = {root_src, 2'b01};
            ge           = (rem_sh >= trial);
            rem_next[k]  = ge ? (rem_sh - trial) : rem_sh;
            root_next[k] = {root_src[ROOT_WIDTH-2:0], ge};
            rad_next[k]  = {rad_src[RAD_WIDTH-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROOT_WIDTH; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < ROOT_WIDTH; k++)
            begin
                valid_reg[k] <= valid_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ROOT_WIDTH; k++)
        begin
            rad_reg[k]  <= rad_next[k];
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
            meta_reg[k] <= meta_next[k];
        end
    end

    assign out_valid = valid_reg[ROOT_WIDTH-1];
    assign out_root  = root_reg[ROOT_WIDTH-1];
    assign out_meta  = meta_reg[ROOT_WIDTH-1];

endmodule

>>> hw/rtl/qrs_div.sv
// ============================================================================
// Pipelined two-lane divider
// Restoring division of two numerator and divisor pairs, one quotient bit per
// register stage, with the item's word carried alongside.
// ============================================================================
module qrs_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [qrs_pkg::NUM_WIDTH-1:0]  in_num1,
    input  logic [qrs_pkg::DEN_WIDTH-1:0]  in_den1,
    input  logic [qrs_pkg::NUM_WIDTH-1:0]  in_num2,
    input  logic [qrs_pkg::DEN_WIDTH-1:0]  in_den2,
    input  qrs_pkg::div_meta_t             in_meta,
    output logic                           out_valid,
    output logic [qrs_pkg::QUO_WIDTH-1:0]  out_quo1,
    output logic [qrs_pkg::DEN_WIDTH-1:0]  out_rem1,
    output logic [qrs_pkg::DEN_WIDTH-1:0]  out_den1,
    output logic [qrs_pkg::QUO_WIDTH-1:0]  out_quo2,
    output logic [qrs_pkg::DEN_WIDTH-1:0]  out_rem2,
    output logic [qrs_pkg::DEN_WIDTH-1:0]  out_den2,
    output qrs_pkg::div_meta_t             out_meta
);
    import qrs_pkg::*;

    logic                  valid_reg  [QUO_WIDTH];
    logic                  valid_next [QUO_WIDTH];
    div_meta_t             meta_reg   [QUO_WIDTH];
    div_meta_t             meta_next  [QUO_WIDTH];
    logic [NUM_WIDTH-1:0]  num_reg    [QUO_WIDTH][2];
    logic [NUM_WIDTH-1:0]  num_next   [QUO_WIDTH][2];
    logic [DEN_WIDTH-1:0]  den_reg    [QUO_WIDTH][2];
    logic [DEN_WIDTH-1:0]  den_next   [QUO_WIDTH][2];
    logic [DEN_WIDTH-1:0]  rem_reg    [QUO_WIDTH][2];
    logic [DEN_WIDTH-1:0]  rem_next   [QUO_WIDTH][2];
    logic [QUO_WIDTH-1:0]  quo_reg    [QUO_WIDTH][2];
    logic [QUO_WIDTH-1:0]  quo_next   [QUO_WIDTH][2];

    always_comb
    begin
        logic [NUM_WIDTH-1:0] num_src;
        logic [DEN_WIDTH-1:0] den_src;
        logic [DEN_WIDTH-1:0] rem_src;
        logic [QUO_WIDTH-1:0] quo_src;
        logic [DEN_WIDTH:0]   rem_sh;
        logic [DEN_WIDTH:0]   diff;
        logic                 ge;
        for (int k = 0; k < QUO_WIDTH; k++)
        begin
            if (k == 0)
            begin
                valid_next[k] = in_valid;
                meta_next[k]  = in_meta;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
                meta_next[k]  = meta_reg[k-1];
            end
            for (int l = 0; l < 2; l++)
            begin
                if (k == 0)
                begin
                    num_src = (l == 0) ? in_num1 : in_num2;
                    den_src = (l == 0) ? in_den1 : in_den2;
                    rem_src = '0;
                    quo_src = '0;
                end
                else
                begin
                    num_src = num_reg[k-1][l];
                    den_src = den_reg[k-1][l];
                    rem_src = rem_reg[k-1][l];
                    quo_src = quo_reg[k-1][l];
                end
                rem_sh         = {rem_src, num_src[NUM_WIDTH-1]};
                ge             = (rem_sh >= {1'b0, den_src});
                diff           = rem_sh - {1'b0, den_src};
                rem_next[k][l] = ge ? diff[DEN_WIDTH-1:0] : rem_sh[DEN_WIDTH-1:0];
                quo_next[k][l] = {quo_src[QUO_WIDTH-2:0], ge};
                num_next[k][l] = {num_src[NUM_WIDTH-2:0], 1'b0};
                den_next[k][l] = den_src;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QUO_WIDTH; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < QUO_WIDTH; k++)
            begin
                valid_reg[k] <= valid_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QUO_WIDTH; k++)
        begin
            meta_reg[k] <= meta_next[k];
            for (int l = 0; l < 2; l++)
            begin
                num_reg[k][l] <= num_next[k][l];
                den_reg[k][l] <= den_next[k][l];
                rem_reg[k][l] <= rem_next[k][l];
                quo_reg[k][l] <= quo_next[k][l];
            end
        end
    end

    assign out_valid = valid_reg[QUO_WIDTH-1];
    assign out_meta  = meta_reg[QUO_WIDTH-1];
    assign out_quo1  = quo_reg[QUO_WIDTH-1][0];
    assign out_rem1  = rem_reg[QUO_WIDTH-1][0];
    assign out_den1  = den_reg[QUO_WIDTH-1][0];
    assign out_quo2  = quo_reg[QUO_WIDTH-1][1];
    assign out_rem2  = rem_reg[QUO_WIDTH-1][1];
    assign out_den2  = den_reg[QUO_WIDTH-1][1];

endmodule

>>> hw/rtl/quadratic_root_solver.sv
// ============================================================================
// Quadratic root solver
// Throughput: one word per cycle; busy stays low and a new word may enter
// every cycle, set by the fully pipelined square root and divider stages.
// Reset clears all valid bits and sets tol_reg to 0.
// The receiver cannot stall, so every result is shown for exactly one cycle.
// ============================================================================
module quadratic_root_solver (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_a,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_b,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_c,
    input  logic                                   cfg_wr_en,
    input  logic [qrs_pkg::TOL_WIDTH-1:0]          cfg_wr_data,
    output logic                                   result_valid,
    output logic [2:0]                             case_code,
    output logic signed [qrs_pkg::DISC_WIDTH-1:0]  disc_value,
    output logic signed [qrs_pkg::OUT_WIDTH-1:0]   first_value,
    output logic signed [qrs_pkg::OUT_WIDTH-1:0]   second_value,
    output logic                                   saturated
);
    import qrs_pkg::*;

    function automatic logic [OUT_WIDTH:0] clamp(input logic neg,
                                                 input logic [QUO_WIDTH:0] q);
        logic [QUO_WIDTH:0]   pos_lim;
        logic [QUO_WIDTH:0]   neg_lim;
        logic [OUT_WIDTH-1:0] qv;
        pos_lim = (QUO_WIDTH+1)'({(OUT_WIDTH-1){1'b1}});
        neg_lim = pos_lim + (QUO_WIDTH+1)'(1);
        qv      = q[OUT_WIDTH-1:0];
        if (!neg && (q > pos_lim))
        begin
            return {1'b1, pos_lim[OUT_WIDTH-1:0]};
        end
        else if (neg && (q > neg_lim))
        begin
            return {1'b1, neg_lim[OUT_WIDTH-1:0]};
        end
        return {1'b0, (neg ? -qv : qv)};
    endfunction

    logic [TOL_WIDTH-1:0] tol_reg;
    logic                 accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            tol_reg <= cfg_wr_data;
        end
    end

    // Input registers.
    logic                         s1_valid_reg;
    logic signed [COEF_WIDTH-1:0] s1_a_reg;
    logic signed [COEF_WIDTH-1:0] s1_b_reg;
    logic signed [COEF_WIDTH-1:0] s1_c_reg;

    // Products and zero tests.
    logic                         s2_valid_reg;
    logic signed [PROD_WIDTH-1:0] s2_bb_reg;
    logic signed [PROD_WIDTH-1:0] s2_ac_reg;
    logic signed [PROD_WIDTH-1:0] s2_bb_next;
    logic signed [PROD_WIDTH-1:0] s2_ac_next;
    logic signed [COEF_WIDTH-1:0] s2_b_reg;
    logic signed [COEF_WIDTH-1:0] s2_c_reg;
    logic                         s2_a_neg_reg;
    logic [COEF_WIDTH-1:0]        s2_mag_a_reg;
    logic [COEF_WIDTH-1:0]        s2_mag_b_reg;
    logic [COEF_WIDTH-1:0]        s2_mag_c_reg;
    logic [COEF_WIDTH-1:0]        s2_mag_a_next;
    logic [COEF_WIDTH-1:0]        s2_mag_b_next;
    logic [COEF_WIDTH-1:0]        s2_mag_c_next;
    logic                         s2_a_zero_reg;
    logic                         s2_b_zero_reg;
    logic                         s2_c_zero_reg;
    logic [COEF_WIDTH-1:0]        tol_coef;

    assign tol_coef      = {{(COEF_WIDTH-TOL_WIDTH){1'b0}}, tol_reg};
    assign s2_bb_next    = s1_b_reg * s1_b_reg;
    assign s2_ac_next    = s1_a_reg * s1_c_reg;
    assign s2_mag_a_next = s1_a_reg[COEF_WIDTH-1] ? -s1_a_reg : s1_a_reg;
    assign s2_mag_b_next = s1_b_reg[COEF_WIDTH-1] ? -s1_b_reg : s1_b_reg;
    assign s2_mag_c_next = s1_c_reg[COEF_WIDTH-1] ? -s1_c_reg : s1_c_reg;

    // Discriminant, case selection and square root radicand.
    logic                        s3_valid_next;
    logic [RAD_WIDTH-1:0]        s3_rad_next;
    sq_meta_t                    s3_meta_next;
    logic signed [D_WIDTH-1:0]   d_val;
    logic [D_WIDTH-1:0]          d_mag;
    logic                        d_pos;
    logic                        nd_small;

    always_comb
    begin
        logic signed [D_WIDTH-1:0] bb_ext;
        logic signed [D_WIDTH-1:0] ac_ext;
        bb_ext   = {{(D_WIDTH-PROD_WIDTH){s2_bb_reg[PROD_WIDTH-1]}}, s2_bb_reg};
        ac_ext   = {{(D_WIDTH-PROD_WIDTH){s2_ac_reg[PROD_WIDTH-1]}}, s2_ac_reg};
        d_val    = bb_ext - (ac_ext <<< 2);
        d_mag    = d_val[D_WIDTH-1] ? -d_val : d_val;
        d_pos    = !d_val[D_WIDTH-1] && (d_val != '0);
        nd_small = (d_mag <= {{(D_WIDTH-TOL_WIDTH){1'b0}}, tol_reg});

        s3_valid_next      = s2_valid_reg;
        s3_rad_next        = {d_mag, {(2*SQRT_SHIFT){1'b0}}};
        s3_meta_next.b     = s2_b_reg;
        s3_meta_next.a_neg = s2_a_neg_reg;
        s3_meta_next.den   = {s2_mag_a_reg, 1'b0};

        if (s2_a_zero_reg)
        begin
            s3_meta_next.disc = '0;
            if (s2_b_zero_reg)
            begin
                s3_meta_next.code = s2_c_zero_reg ? CASE_INF : CASE_NONE;
                s3_meta_next.num1 = '0;
                s3_meta_next.den1 = DEN_WIDTH'(1);
                s3_meta_next.neg1 = 1'b0;
            end
            else
            begin
                s3_meta_next.code = CASE_LINEAR;
                s3_meta_next.num1 = NUM_WIDTH'({s2_mag_c_reg, {ROOT_FRAC{1'b0}}});
                s3_meta_next.den1 = {1'b0, s2_mag_b_reg};
                s3_meta_next.neg1 = (s2_c_reg != '0) &&
                                    (s2_c_reg[COEF_WIDTH-1] == s2_b_reg[COEF_WIDTH-1]);
            end
        end
        else
        begin
            s3_meta_next.disc = {{(DISC_WIDTH-D_WIDTH){d_val[D_WIDTH-1]}}, d_val};
            if (d_pos)
            begin
                s3_meta_next.code = CASE_TWO;
            end
            else if (nd_small)
            begin
                s3_meta_next.code = CASE_DOUBLE;
            end
            else
            begin
                s3_meta_next.code = CASE_CPLX;
            end
            s3_meta_next.num1 = NUM_WIDTH'({s2_mag_b_reg, {ROOT_FRAC{1'b0}}});
            s3_meta_next.den1 = {s2_mag_a_reg, 1'b0};
            s3_meta_next.neg1 = (s2_b_reg != '0) &&
                                (s2_b_reg[COEF_WIDTH-1] == s2_a_neg_reg);
        end
    end

    logic                  s3_valid_reg;
    logic [RAD_WIDTH-1:0]  s3_rad_reg;
    sq_meta_t              s3_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_a_reg      <= coef_a;
        s1_b_reg      <= coef_b;
        s1_c_reg      <= coef_c;
        s2_bb_reg     <= s2_bb_next;
        s2_ac_reg     <= s2_ac_next;
        s2_b_reg      <= s1_b_reg;
        s2_c_reg      <= s1_c_reg;
        s2_a_neg_reg  <= s1_a_reg[COEF_WIDTH-1];
        s2_mag_a_reg  <= s2_mag_a_next;
        s2_mag_b_reg  <= s2_mag_b_next;
        s2_mag_c_reg  <= s2_mag_c_next;
        s2_a_zero_reg <= (s2_mag_a_next <= tol_coef);
        s2_b_zero_reg <= (s2_mag_b_next <= tol_coef);
        s2_c_zero_reg <= (s2_mag_c_next <= tol_coef);
        s3_rad_reg    <= s3_rad_next;
        s3_meta_reg   <= s3_meta_next;
    end

    logic                   sq_valid;
    logic [ROOT_WIDTH-1:0]  sq_root;
    sq_meta_t               sq_meta;

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_rad    (s3_rad_reg),
        .in_meta   (s3_meta_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_meta  (sq_meta)
    );

    // Root numerators.
    logic [NUM_WIDTH-1:0]  s4_num1_next;
    logic [NUM_WIDTH-1:0]  s4_num2_next;
    logic [DEN_WIDTH-1:0]  s4_den1_next;
    logic [DEN_WIDTH-1:0]  s4_den2_next;
    div_meta_t             s4_meta_next;

    always_comb
    begin
        logic signed [N_WIDTH-1:0] bs;
        logic signed [N_WIDTH-1:0] sq_ext;
        logic signed [N_WIDTH-1:0] n1;
        logic signed [N_WIDTH-1:0] n2;
        logic [N_WIDTH-1:0]        n1_mag;
        logic [N_WIDTH-1:0]        n2_mag;
        bs     = {{(N_WIDTH-COEF_WIDTH){sq_meta.b[COEF_WIDTH-1]}}, sq_meta.b} <<< SQRT_SHIFT;
        sq_ext = {2'b00, sq_root};
        n1     = sq_ext - bs;
        n2     = -(bs + sq_ext);
        n1_mag = n1[N_WIDTH-1] ? -n1 : n1;
        n2_mag = n2[N_WIDTH-1] ? -n2 : n2;

        s4_meta_next.code = sq_meta.code;
        s4_meta_next.disc = sq_meta.disc;
        s4_num1_next      = sq_meta.num1;
        s4_den1_next      = sq_meta.den1;
        s4_meta_next.neg1 = sq_meta.neg1;
        s4_num2_next      = '0;
        s4_den2_next      = DEN_WIDTH'(1);
        s4_meta_next.neg2 = 1'b0;

        case (sq_meta.code)
            CASE_TWO:
            begin
                s4_num1_next      = NUM_WIDTH'({n1_mag, {POST_SHIFT{1'b0}}});
                s4_den1_next      = sq_meta.den;
                s4_meta_next.neg1 = (n1 != '0) && (n1[N_WIDTH-1] != sq_meta.a_neg);
                s4_num2_next      = NUM_WIDTH'({n2_mag, {POST_SHIFT{1'b0}}});
                s4_den2_next      = sq_meta.den;
                s4_meta_next.neg2 = (n2 != '0) && (n2[N_WIDTH-1] != sq_meta.a_neg);
            end
            CASE_CPLX:
            begin
                s4_num2_next = NUM_WIDTH'({sq_root, {POST_SHIFT{1'b0}}});
                s4_den2_next = sq_meta.den;
            end
            default:
            begin
                s4_num2_next = '0;
            end
        endcase
    end

    logic                  s4_valid_reg;
    logic [NUM_WIDTH-1:0]  s4_num1_reg;
    logic [NUM_WIDTH-1:0]  s4_num2_reg;
    logic [DEN_WIDTH-1:0]  s4_den1_reg;
    logic [DEN_WIDTH-1:0]  s4_den2_reg;
    div_meta_t             s4_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_num1_reg <= s4_num1_next;
        s4_num2_reg <= s4_num2_next;
        s4_den1_reg <= s4_den1_next;
        s4_den2_reg <= s4_den2_next;
        s4_meta_reg <= s4_meta_next;
    end

    logic                  dv_valid;
    logic [QUO_WIDTH-1:0]  dv_quo1;
    logic [QUO_WIDTH-1:0]  dv_quo2;
    logic [DEN_WIDTH-1:0]  dv_rem1;
    logic [DEN_WIDTH-1:0]  dv_rem2;
    logic [DEN_WIDTH-1:0]  dv_den1;
    logic [DEN_WIDTH-1:0]  dv_den2;
    div_meta_t             dv_meta;

    qrs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .in_num1   (s4_num1_reg),
        .in_den1   (s4_den1_reg),
        .in_num2   (s4_num2_reg),
        .in_den2   (s4_den2_reg),
        .in_meta   (s4_meta_reg),
        .out_valid (dv_valid),
        .out_quo1  (dv_quo1),
        .out_rem1  (dv_rem1),
        .out_den1  (dv_den1),
        .out_quo2  (dv_quo2),
        .out_rem2  (dv_rem2),
        .out_den2  (dv_den2),
        .out_meta  (dv_meta)
    );

    // Rounding to nearest, ties away from zero.
    logic                s5_valid_reg;
    logic [QUO_WIDTH:0]  s5_q1_reg;
    logic [QUO_WIDTH:0]  s5_q2_reg;
    logic [QUO_WIDTH:0]  s5_q1_next;
    logic [QUO_WIDTH:0]  s5_q2_next;
    div_meta_t           s5_meta_reg;

    assign s5_q1_next = {1'b0, dv_quo1} +
                        (QUO_WIDTH+1)'({dv_rem1, 1'b0} >= {1'b0, dv_den1});
    assign s5_q2_next = {1'b0, dv_quo2} +
                        (QUO_WIDTH+1)'({dv_rem2, 1'b0} >= {1'b0, dv_den2});

    // Saturation and case selection into the output register.
    logic                         out_valid_reg;
    logic [2:0]                   out_code_reg;
    logic signed [DISC_WIDTH-1:0] out_disc_reg;
    logic signed [OUT_WIDTH-1:0]  out_first_reg;
    logic signed [OUT_WIDTH-1:0]  out_second_reg;
    logic                         out_sat_reg;
    logic signed [OUT_WIDTH-1:0]  out_first_next;
    logic signed [OUT_WIDTH-1:0]  out_second_next;
    logic                         out_sat_next;
    logic [OUT_WIDTH:0]           r1;
    logic [OUT_WIDTH:0]           r2;

    assign r1 = clamp(s5_meta_reg.neg1, s5_q1_reg);
    assign r2 = clamp(s5_meta_reg.neg2, s5_q2_reg);

    always_comb
    begin
        case (s5_meta_reg.code)
            CASE_LINEAR:
            begin
                out_first_next  = r1[OUT_WIDTH-1:0];
                out_second_next = '0;
                out_sat_next    = r1[OUT_WIDTH];
            end
            CASE_TWO, CASE_CPLX:
            begin
                out_first_next  = r1[OUT_WIDTH-1:0];
                out_second_next = r2[OUT_WIDTH-1:0];
                out_sat_next    = r1[OUT_WIDTH] | r2[OUT_WIDTH];
            end
            CASE_DOUBLE:
            begin
                out_first_next  = r1[OUT_WIDTH-1:0];
                out_second_next = r1[OUT_WIDTH-1:0];
                out_sat_next    = r1[OUT_WIDTH];
            end
            default:
            begin
                out_first_next  = '0;
                out_second_next = '0;
                out_sat_next    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg  <= dv_valid;
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_q1_reg      <= s5_q1_next;
        s5_q2_reg      <= s5_q2_next;
        s5_meta_reg    <= dv_meta;
        out_code_reg   <= s5_meta_reg.code;
        out_disc_reg   <= s5_meta_reg.disc;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
        out_sat_reg    <= out_sat_next;
    end

    assign result_valid = out_valid_reg;
    assign case_code    = out_code_reg;
    assign disc_value   = out_disc_reg;
    assign first_value  = out_first_reg;
    assign second_value = out_second_reg;
    assign saturated    = out_sat_reg;

    a_double_same: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (case_code == CASE_DOUBLE)) |-> (second_value == first_value))
        else $error("Double root words differ.");

    a_no_disc: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && ((case_code == CASE_INF) || (case_code == CASE_NONE) ||
                          (case_code == CASE_LINEAR))) |-> (disc_value == '0))
        else $error("Discriminant is not zero for a degenerate equation.");

    a_no_roots: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && ((case_code == CASE_INF) || (case_code == CASE_NONE)))
        |-> ((first_value == '0) && (second_value == '0) && !saturated))
        else $error("Root words are set for an equation without roots.");

    a_imag_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (case_code == CASE_CPLX)) |-> !second_value[OUT_WIDTH-1])
        else $error("Imaginary part is negative.");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg |=> result_valid)
        else $error("A rounded word was lost before the output register.");

endmodule
